>>> design/fit_policy_block_allocator_unit_macros.svh
// Assertion macros shared by the allocator RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// pre holds -> post holds in the same cycle
`define FPBA_ASSERT_NOW(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("allocator check failed");
// pre holds -> post holds in the next cycle
`define FPBA_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("allocator check failed");
`else
`define FPBA_ASSERT_NOW(label, clk, rstn, pre, post)
`define FPBA_ASSERT_NEXT(label, clk, rstn, pre, post)
`endif

`endif

>>> design/fpba_pkg.sv
// Shared types and constants for the fit policy block allocator.
// No dependencies; used by fpba_pick and the top level.
`timescale 1ns / 1ps

package fpba_pkg;

    localparam int MAX_BLOCKS = 16;
    localparam int ADDR_BITS  = 16;
    localparam int FIELD_BITS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_BITS   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_BITS   = $clog2(MAX_BLOCKS + 1);

    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [SIZE_BITS-1:0]  size_t;
    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;

    // function codes
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    // fit policy codes
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_ADDED     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic                  func;
        logic [1:0]            policy;
        logic [FIELD_BITS-1:0] block_start;
        logic [FIELD_BITS-1:0] amount;
    } in_beat_t;

    typedef struct packed {
        status_t               status;
        logic [FIELD_BITS-1:0] alloc_address;
    } out_beat_t;

    // one table entry
    typedef struct packed {
        addr_t start;
        size_t size;
    } entry_t;

    // control from the scan sequencer to the picker
    typedef struct packed {
        logic       clear;
        logic       valid;
        logic [1:0] policy;
        size_t      job;
        idx_t       idx;
    } pick_ctrl_t;

    // current winner held by the picker
    typedef struct packed {
        logic   found;
        idx_t   idx;
        entry_t ent;
    } pick_stat_t;

endpackage

>>> design/fpba_pick.sv
// Fit picker: watches the streamed table entries and keeps the winner.
// Depends on fpba_pkg.
`timescale 1ns / 1ps

module fpba_pick (
    input  logic                aclk,
    input  logic                aresetn,
    input  fpba_pkg::pick_ctrl_t ctrl,
    input  fpba_pkg::entry_t    ent,
    output fpba_pkg::pick_stat_t stat
);
    import fpba_pkg::*;

    logic   found_reg;
    idx_t   idx_reg;
    entry_t ent_reg;
    logic   fits;
    logic   take;

    // candidate test; ties keep the earlier entry
    always_comb begin
        fits = (ent.size >= ctrl.job);
        take = 1'b0;
        if (ctrl.valid && fits) begin
            if (!found_reg) begin
                take = 1'b1;
            end else begin
                case (ctrl.policy)
                    POL_BEST:  take = (ent.size < ent_reg.size);
                    POL_WORST: take = (ent.size > ent_reg.size);
                    default:   take = 1'b0;
                endcase
            end
        end
    end

    // winner registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (ctrl.clear) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            idx_reg <= ctrl.idx;
            ent_reg <= ent;
        end
    end

    assign stat.found = found_reg;
    assign stat.idx   = idx_reg;
    assign stat.ent   = ent_reg;

endmodule

>>> design/fit_policy_block_allocator_unit.sv
// An add, or an allocation refused up front (unknown policy or empty table), goes from the
// accepted beat straight to the response state; a scanned allocation reads the N stored
// blocks (1..16), waits for the last read to reach the picker and for the picker to
// settle, writes the winner back, then responds. One item at a time: no new beat is
// taken until the reply enters the output register; a finished result waits in the
// response state while that register is full. Sync active-low reset clears control only.
`timescale 1ns / 1ps
`include "fit_policy_block_allocator_unit_macros.svh"

module fit_policy_block_allocator_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fpba_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fpba_pkg::out_beat_t m_data
);
    import fpba_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPD,
        S_RESP
    } state_t;

    state_t     state_reg;
    cnt_t       count_reg;
    cnt_t       scan_cnt_reg;
    logic       rd_pend_reg;
    idx_t       rd_idx_reg;
    logic [1:0] policy_reg;
    size_t      job_reg;
    out_beat_t  res_reg;
    logic       m_valid_reg;
    out_beat_t  m_data_reg;

    entry_t     mem [MAX_BLOCKS];
    entry_t     rd_data_reg;

    logic       acc;
    logic       rd_en;
    idx_t       rd_addr;
    logic       wr_en;
    idx_t       wr_addr;
    entry_t     wr_data;
    logic       full;

    pick_ctrl_t pick_ctrl;
    pick_stat_t pick_stat;

    assign s_ready = (state_reg == S_IDLE);
    assign acc     = s_valid && s_ready;
    assign full    = (count_reg == cnt_t'(MAX_BLOCKS));
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // table read: one entry per scan cycle
    assign rd_en   = (state_reg == S_SCAN) && (scan_cnt_reg < count_reg);
    assign rd_addr = scan_cnt_reg[IDX_BITS-1:0];

    // table write: append on add, update the winner after a scan
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = count_reg[IDX_BITS-1:0];
        wr_data.start = addr_t'(s_data.block_start);
        wr_data.size  = size_t'(s_data.amount);
        if (acc && (s_data.func == FUNC_ADD) && !full) begin
            wr_en = 1'b1;
        end else if ((state_reg == S_UPD) && pick_stat.found) begin
            wr_en         = 1'b1;
            wr_addr       = pick_stat.idx;
            wr_data.start = pick_stat.ent.start + addr_t'(job_reg);
            wr_data.size  = pick_stat.ent.size - job_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // picker hookup
    always_comb begin
        pick_ctrl.clear  = acc && (s_data.func == FUNC_ALLOC);
        pick_ctrl.valid  = rd_pend_reg;
        pick_ctrl.policy = policy_reg;
        pick_ctrl.job    = job_reg;
        pick_ctrl.idx    = rd_idx_reg;
    end

    fpba_pick u_pick (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (pick_ctrl),
        .ent     (rd_data_reg),
        .stat    (pick_stat)
    );

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            scan_cnt_reg <= '0;
            rd_pend_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            rd_pend_reg <= rd_en;
            rd_idx_reg  <= rd_addr;
            // the response state loads the output register itself
            if (m_valid_reg && m_ready && (state_reg != S_RESP)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (acc) begin
                        policy_reg <= s_data.policy;
                        job_reg    <= size_t'(s_data.amount);
                        res_reg.alloc_address <= '0;
                        if (s_data.func == FUNC_ADD) begin
                            if (full) begin
                                res_reg.status <= ST_FULL;
                            end else begin
                                count_reg      <= count_reg + cnt_t'(1);
                                res_reg.status <= ST_ADDED;
                            end
                            state_reg <= S_RESP;
                        end else if (!(s_data.policy inside {POL_FIRST, POL_BEST, POL_WORST})
                                     || (count_reg == '0)) begin
                            res_reg.status <= ST_NO_FIT;
                            state_reg      <= S_RESP;
                        end else begin
                            scan_cnt_reg <= '0;
                            state_reg    <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_cnt_reg < count_reg) begin
                        scan_cnt_reg <= scan_cnt_reg + cnt_t'(1);
                    end else if (!rd_pend_reg) begin
                        state_reg <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (pick_stat.found) begin
                        res_reg.status        <= ST_ALLOCATED;
                        res_reg.alloc_address <= FIELD_BITS'(pick_stat.ent.start);
                    end else begin
                        res_reg.status        <= ST_NO_FIT;
                        res_reg.alloc_address <= '0;
                    end
                    state_reg <= S_RESP;
                end
                S_RESP: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    `FPBA_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= cnt_t'(MAX_BLOCKS))
    `FPBA_ASSERT_NEXT(a_add_counts, aclk, aresetn, acc && (s_data.func == FUNC_ADD) && !full, count_reg == $past(count_reg) + cnt_t'(1))
    `FPBA_ASSERT_NOW(a_addr_zero, aclk, aresetn, m_valid_reg && (m_data_reg.status != ST_ALLOCATED), m_data_reg.alloc_address == '0)
    `FPBA_ASSERT_NOW(a_pick_in_table, aclk, aresetn, (state_reg == S_UPD) && pick_stat.found, cnt_t'(pick_stat.idx) < count_reg)

endmodule

>>> dv/testbench.sv
// Self-checking testbench for fit_policy_block_allocator_unit.
// Drives add/allocate beats, predicts each reply from a private free-block table,
// checks replies in order. Depends on fpba_pkg and the allocator RTL.
`timescale 1ns / 1ps

module testbench;
    import fpba_pkg::*;

    // policy code with no fit rule behind it
    localparam logic [1:0] POL_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int END_SETTLE = 40;
    localparam int RANDOM_BEATS = 1900;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    fit_policy_block_allocator_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // predicted free-block table
    addr_t fl_start [MAX_BLOCKS];
    size_t fl_size  [MAX_BLOCKS];
    int    fl_count;

    out_beat_t pending_replies[$];
    int        n_errors;
    int        cycle_count;
    bit        idle_on;
    int        rx_hold_left;

    // 2 ns clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // gap length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // reply for one beat; updates the predicted table
    function automatic out_beat_t alloc_outcome(in_beat_t b);
        out_beat_t r;
        int        pick;
        r.status = ST_NO_FIT;
        r.alloc_address = '0;
        pick = -1;
        if (b.func == FUNC_ADD) begin
            if (fl_count >= MAX_BLOCKS) begin
                r.status = ST_FULL;
            end else begin
                fl_start[fl_count] = addr_t'(b.block_start);
                fl_size[fl_count] = size_t'(b.amount);
                fl_count++;
                r.status = ST_ADDED;
            end
        end else if (b.policy == POL_FIRST || b.policy == POL_BEST
                     || b.policy == POL_WORST) begin
            // scan in table order; ties keep the earliest entry
            for (int i = 0; i < fl_count; i++) begin
                if (fl_size[i] >= size_t'(b.amount)) begin
                    if (pick < 0) begin
                        pick = i;
                        if (b.policy == POL_FIRST) break;
                    end else if (b.policy == POL_BEST && fl_size[i] < fl_size[pick]) begin
                        pick = i;
                    end else if (b.policy == POL_WORST && fl_size[i] > fl_size[pick]) begin
                        pick = i;
                    end
                end
            end
            if (pick >= 0) begin
                r.status = ST_ALLOCATED;
                r.alloc_address = FIELD_BITS'(fl_start[pick]);
                fl_start[pick] = fl_start[pick] + addr_t'(b.amount);
                fl_size[pick] = fl_size[pick] - size_t'(b.amount);
            end
        end
        return r;
    endfunction

    function automatic in_beat_t make_beat(logic f, logic [1:0] pol, int start, int amt);
        in_beat_t b;
        b.func = f;
        b.policy = pol;
        b.block_start = FIELD_BITS'(start);
        b.amount = FIELD_BITS'(amt);
        return b;
    endfunction

    // offer one beat, hold it until taken, then record its reply
    task automatic send_beat(in_beat_t b);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 99) < 35) gap = pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_data = b;
        do @(posedge aclk); while (!s_ready);
        pending_replies.push_back(alloc_outcome(b));
    endtask

    task automatic idle_input();
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic wait_drained();
        idle_input();
        while (pending_replies.size() != 0) @(posedge aclk);
    endtask

    // result side: random stalls, plus a long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_left > 0) begin
                m_ready = 1'b0;
                rx_hold_left--;
            end else if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                m_ready = 1'b1;
                if (idle_on && $urandom_range(0, 99) < 30) stall_left = pick_gap();
            end
        end
    end

    // reply checker
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected reply: status %0d addr %h",
                             m_data.status, m_data.alloc_address);
            end else begin
                want = pending_replies.pop_front();
                if (m_data.status !== want.status
                    || m_data.alloc_address !== want.alloc_address) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("reply mismatch: expected status %0d addr %h, got status %0d addr %h",
                                 want.status, want.alloc_address,
                                 m_data.status, m_data.alloc_address);
                end
            end
        end
    end

    // allocations against an empty table, all policies
    task automatic test_empty_table();
        send_beat(make_beat(FUNC_ALLOC, POL_FIRST, 16'h0000, 16'h0000));
        send_beat(make_beat(FUNC_ALLOC, POL_BEST, 16'hFFFF, 16'hFFFF));
        send_beat(make_beat(FUNC_ALLOC, POL_WORST, 16'h0000, 16'h0001));
        send_beat(make_beat(FUNC_ALLOC, POL_UNKNOWN, 16'hFFFF, 16'h0000));
    endtask

    // small table with ties, wrap, zero size job and exact fits
    task automatic test_fit_policies();
        send_beat(make_beat(FUNC_ADD, POL_FIRST, 16'hFFF0, 16'h0100));
        send_beat(make_beat(FUNC_ADD, POL_BEST, 16'h1000, 16'h0040));
        send_beat(make_beat(FUNC_ADD, POL_WORST, 16'h2000, 16'h0100));
        send_beat(make_beat(FUNC_ADD, POL_UNKNOWN, 16'h0000, 16'hFFFF));
        send_beat(make_beat(FUNC_ADD, POL_FIRST, 16'h3000, 16'h0040));
        send_beat(make_beat(FUNC_ADD, POL_FIRST, 16'hFFFF, 16'h0000));
        send_beat(make_beat(FUNC_ALLOC, POL_FIRST, 16'h0000, 16'h0020));
        send_beat(make_beat(FUNC_ALLOC, POL_BEST, 16'h0000, 16'h0040));
        send_beat(make_beat(FUNC_ALLOC, POL_WORST, 16'h0000, 16'h0010));
        send_beat(make_beat(FUNC_ALLOC, POL_FIRST, 16'h0000, 16'h0000));
        send_beat(make_beat(FUNC_ALLOC, POL_BEST, 16'h0000, 16'h0000));
        send_beat(make_beat(FUNC_ALLOC, POL_UNKNOWN, 16'h0000, 16'h0010));
        send_beat(make_beat(FUNC_ALLOC, POL_WORST, 16'h0000, 16'hFFFF));
        send_beat(make_beat(FUNC_ALLOC, POL_BEST, 16'h0000, 16'h0100));
        send_beat(make_beat(FUNC_ALLOC, POL_FIRST, 16'h0000, 16'hFFEF));
        send_beat(make_beat(FUNC_ALLOC, POL_WORST, 16'h0000, 16'h0040));
        // sender pauses until every reply is back
        wait_drained();
    endtask

    // random mix; the table fills along the way
    task automatic test_random_mix();
        int r, sz, amt, start;
        logic [1:0] pol;
        for (int k = 0; k < RANDOM_BEATS; k++) begin
            idle_on = ((k / 200) % 4) != 3;
            start = $urandom_range(0, 65535);
            r = $urandom_range(0, 99);
            if (r < ((fl_count < MAX_BLOCKS) ? 12 : 4)) begin
                r = $urandom_range(0, 99);
                if (r < 35) amt = $urandom_range(0, 65535);
                else if (r < 60 && fl_count > 0) amt = fl_size[$urandom_range(0, fl_count - 1)];
                else amt = $urandom_range(0, 1023);
                send_beat(make_beat(FUNC_ADD, 2'($urandom_range(0, 3)), start, amt));
            end else begin
                r = $urandom_range(0, 9);
                if (r < 3) pol = POL_FIRST;
                else if (r < 6) pol = POL_BEST;
                else if (r < 9) pol = POL_WORST;
                else pol = POL_UNKNOWN;
                sz = (fl_count > 0) ? int'(fl_size[$urandom_range(0, fl_count - 1)]) : 0;
                // job sizes: mostly small, some exact or just over a stored block
                r = $urandom_range(0, 99);
                if (r < 55) amt = $urandom_range(0, 127);
                else if (r < 65) amt = 0;
                else if (r < 75) amt = $urandom_range(0, 65535);
                else if (r < 85) amt = (sz <= 4096) ? sz : $urandom_range(0, sz >> 4);
                else if (r < 95) amt = (sz < 65535) ? sz + 1 : sz;
                else amt = $urandom_range(sz >> 1, sz);
                send_beat(make_beat(FUNC_ALLOC, pol, start, amt));
            end
        end
        idle_on = 1'b1;
    endtask

    // receiver holds off while beats keep coming, so the input stalls
    task automatic test_output_stall();
        idle_on = 1'b0;
        rx_hold_left = 300;
        for (int k = 0; k < 24; k++)
            send_beat(make_beat(FUNC_ALLOC, 2'($urandom_range(0, 2)),
                                $urandom_range(0, 65535), $urandom_range(0, 31)));
        wait_drained();
        idle_on = 1'b1;
    endtask

    // fill whatever is left, then one add too many
    task automatic test_table_full();
        while (fl_count < MAX_BLOCKS)
            send_beat(make_beat(FUNC_ADD, POL_FIRST, $urandom_range(0, 65535),
                                $urandom_range(0, 65535)));
        send_beat(make_beat(FUNC_ADD, POL_UNKNOWN, 16'hFFFF, 16'hFFFF));
        send_beat(make_beat(FUNC_ALLOC, POL_WORST, 16'h0000, 16'h0001));
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        fl_count = 0;
        n_errors = 0;
        idle_on = 1'b1;
        rx_hold_left = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_table();
        test_fit_policies();
        test_random_mix();
        test_output_stall();
        test_table_full();

        wait_drained();
        repeat (END_SETTLE) @(posedge aclk);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
